[sv/joystick_axis_calibrate_normalize_top_macros.svh]
// Assertion helpers for the top-level RTL file.
// The enclosing scope must provide clk and arst_n.
`ifndef JOYSTICK_AXIS_CALIBRATE_NORMALIZE_TOP_MACROS_SVH
`define JOYSTICK_AXIS_CALIBRATE_NORMALIZE_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define JACN_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define JACN_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define JACN_ASSERT_IMP(lbl, ante, cons, msg)
`define JACN_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

[sv/jacn_pkg.sv]
`timescale 1ns / 1ps

package jacn_pkg;

	localparam int AXIS_W = 5;
	localparam int WORD_W = 2;
	localparam int VAL_W  = 17;
	localparam int POS_W  = 16;
	localparam int COEF_W = 31;
	localparam int SPAN_W = VAL_W + 1;
	localparam int DMAG_W = VAL_W;            // |deflection| <= 2^17-1
	localparam int PROD_W = DMAG_W + COEF_W;
	localparam int FRAC_W = 15;
	localparam int MAG_W  = PROD_W - FRAC_W;

	localparam int IN_TDATA_W  = 24;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 24;
	localparam int OUT_TUSER_W = 1;

	typedef enum logic [1:0] {
		REQ_SAMPLE = 2'd0,
		REQ_START  = 2'd1,
		REQ_STOP   = 2'd2,
		REQ_LOAD   = 2'd3
	} req_t;

	localparam logic [WORD_W-1:0] WORD_MIN = 2'd0;
	localparam logic [WORD_W-1:0] WORD_MAX = 2'd1;
	localparam logic [WORD_W-1:0] WORD_CTR = 2'd2;

	typedef enum logic [1:0] {
		ROW_LOAD,
		ROW_CAL,
		ROW_SAMP,
		ROW_STOP
	} row_mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ROW,
		ST_MUL,
		ST_OUT,
		ST_SW_RD,
		ST_SW_ROW,
		ST_DIV_P,
		ST_WAIT_P,
		ST_DIV_N,
		ST_WAIT_N,
		ST_WR
	} state_t;

	// one table row per axis
	typedef struct packed {
		logic [VAL_W-1:0]  mn;
		logic [VAL_W-1:0]  mx;
		logic [VAL_W-1:0]  ctr;
		logic [POS_W-1:0]  last;
		logic [COEF_W-1:0] pc;
		logic [COEF_W-1:0] nc;
	} row_t;

	localparam logic [VAL_W-1:0]  RAW_MIN  = 17'h1_8000;   // -32768
	localparam logic [VAL_W-1:0]  RAW_MAX  = 17'h0_7FFF;   // 32767
	localparam logic [VAL_W-1:0]  RST_MAX  = 17'h0_8000;   // 32768
	localparam logic [COEF_W-1:0] COEF_ONE = 31'h4000_0000;
	localparam logic [COEF_W-1:0] COEF_RST = 31'd32768;

	localparam row_t ROW_RESET = '{
		mn:   RAW_MIN,
		mx:   RST_MAX,
		ctr:  '0,
		last: '0,
		pc:   COEF_RST,
		nc:   COEF_RST
	};

	typedef struct packed {
		logic      take;
		logic      rd_sweep;
		logic      row_ld;
		row_mode_t row_mode;
		logic      d_ld;
		logic      wr;
		logic      div_start;
		logic      div_neg;
		logic      set_pc;
		logic      set_nc;
		logic      mul;
		logic      out_ld;
		logic      cal_set;
		logic      cal_clr;
		logic      seen_clr;
		logic      seen_set;
		logic      sw_clr;
		logic      sw_inc;
	} cmd_t;

	typedef struct packed {
		req_t kind;
		logic axis_ok;
		logic word_ok;
		logic cal;
		logic sw_last;
		logic div_done;
		logic out_busy;
	} sts_t;

endpackage

[sv/jacn_div.sv]
`timescale 1ns / 1ps

// floor(2^30 / span), one quotient bit per cycle; span <= 0 gives 2^30 at once
module jacn_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [jacn_pkg::SPAN_W-1:0] span,
	output logic                        done,
	output logic [jacn_pkg::COEF_W-1:0] quo
);
	import jacn_pkg::*;

	localparam int STEPS = COEF_W;
	localparam int CNT_W = $clog2(STEPS);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [DMAG_W-1:0]  dvs_q;
	logic [DMAG_W-1:0]  rem_q;
	logic [COEF_W-1:0]  dvd_q;
	logic [COEF_W-1:0]  quo_q;
	logic [DMAG_W:0]    trial;
	logic [DMAG_W:0]    diff;
	logic               ge;
	logic               span_le0;

	assign trial    = {rem_q, dvd_q[COEF_W-1]};
	assign diff     = trial - {1'b0, dvs_q};
	assign ge       = trial >= {1'b0, dvs_q};
	assign span_le0 = span[SPAN_W-1] || (span == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= !span_le0;
				done_q <= span_le0;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= COEF_ONE;
			dvs_q <= span[DMAG_W-1:0];
			quo_q <= COEF_ONE;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DMAG_W-1:0] : trial[DMAG_W-1:0];
			dvd_q <= {dvd_q[COEF_W-2:0], 1'b0};
			quo_q <= {quo_q[COEF_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

[sv/jacn_dp.sv]
`timescale 1ns / 1ps

module jacn_dp #(
	parameter int NUM_AXES = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  jacn_pkg::cmd_t                   cmd,
	output jacn_pkg::sts_t                   sts,
	input  logic                             s_tvalid,
	input  logic [jacn_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic [jacn_pkg::IN_TUSER_W-1:0]  s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [jacn_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic [jacn_pkg::OUT_TUSER_W-1:0] m_tuser
);
	import jacn_pkg::*;

	localparam int AW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

	function automatic logic [POS_W-1:0] sat16(input logic [VAL_W-1:0] v);
		if (v[VAL_W-1] == v[VAL_W-2])
			return v[POS_W-1:0];
		return v[VAL_W-1] ? 16'h8000 : 16'h7FFF;
	endfunction

	// input fields
	logic                accept;
	logic [AXIS_W-1:0]   in_axis;
	logic                in_ok;

	assign accept  = s_tvalid && cmd.take;
	assign in_axis = s_tdata[4:0];
	assign in_ok   = int'(in_axis) < NUM_AXES;

	req_t                kind_q;
	logic [AXIS_W-1:0]   ax_q;
	logic [AW-1:0]       idx_q;
	logic [WORD_W-1:0]   word_q;
	logic [VAL_W-1:0]    val_q;
	logic                axis_ok_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q    <= req_t'(s_tuser);
			ax_q      <= in_axis;
			idx_q     <= AW'(in_axis);
			word_q    <= s_tdata[6:5];
			val_q     <= s_tdata[23:7];
			axis_ok_q <= in_ok;
		end
	end

	// control state
	logic                cal_q;
	logic [NUM_AXES-1:0] seen_q;
	logic [NUM_AXES-1:0] vld_q;
	logic                rd_vld_q;
	logic [AW-1:0]       sw_q;
	logic                m_valid_q;
	logic [AW-1:0]       sel_idx;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;

	assign sel_idx = (kind_q == REQ_STOP) ? sw_q : idx_q;
	assign rd_en   = (accept && in_ok) || cmd.rd_sweep;
	assign rd_addr = cmd.rd_sweep ? sw_q : AW'(in_axis);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q     <= 1'b0;
			seen_q    <= '0;
			vld_q     <= '0;
			rd_vld_q  <= 1'b0;
			sw_q      <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cmd.cal_set)
				cal_q <= 1'b1;
			else if (cmd.cal_clr)
				cal_q <= 1'b0;
			if (cmd.seen_clr)
				seen_q <= '0;
			else if (cmd.seen_set)
				seen_q[sel_idx] <= 1'b1;
			if (cmd.wr)
				vld_q[sel_idx] <= 1'b1;
			if (rd_en)
				rd_vld_q <= vld_q[rd_addr];
			if (cmd.sw_clr)
				sw_q <= '0;
			else if (cmd.sw_inc)
				sw_q <= sw_q + 1'b1;
			if (cmd.out_ld)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
		end
	end

	// axis table, one row per axis; rows never written read as the reset row
	row_t mem_q [NUM_AXES];
	row_t rd_row_q;
	row_t base;
	row_t nrow;
	row_t row_q;
	logic seen_cur;

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_row_q <= mem_q[rd_addr];
		if (cmd.wr)
			mem_q[sel_idx] <= row_q;
	end

	assign base     = rd_vld_q ? rd_row_q : ROW_RESET;
	assign seen_cur = seen_q[sel_idx];

	always_comb begin
		nrow = base;
		case (cmd.row_mode)
			ROW_LOAD: begin
				case (word_q)
					WORD_MIN: nrow.mn  = val_q;
					WORD_MAX: nrow.mx  = val_q;
					WORD_CTR: nrow.ctr = val_q;
					default:  nrow     = base;
				endcase
			end
			ROW_CAL: begin
				nrow.last = sat16(val_q);
				if (!seen_cur) begin
					nrow.mn = val_q;
					nrow.mx = val_q;
				end else begin
					if ($signed(val_q) < $signed(base.mn))
						nrow.mn = val_q;
					if ($signed(val_q) > $signed(base.mx))
						nrow.mx = val_q;
				end
			end
			ROW_SAMP: nrow.last = sat16(val_q);
			ROW_STOP: begin
				nrow.ctr = {base.last[POS_W-1], base.last};
				if (cal_q && !seen_cur) begin
					nrow.mn = RAW_MIN;
					nrow.mx = RAW_MAX;
				end
			end
			default: nrow = base;
		endcase
	end

	// coefficient division
	logic [SPAN_W-1:0] span;
	logic              div_done;
	logic [COEF_W-1:0] div_quo;

	assign span = cmd.div_neg ?
		({row_q.ctr[VAL_W-1], row_q.ctr} - {row_q.mn[VAL_W-1], row_q.mn}) :
		({row_q.mx[VAL_W-1], row_q.mx} - {row_q.ctr[VAL_W-1], row_q.ctr});

	jacn_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.span   (span),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.row_ld)
			row_q <= nrow;
		else if (cmd.set_pc)
			row_q.pc <= div_quo;
		else if (cmd.set_nc)
			row_q.nc <= div_quo;
	end

	// deflection and scaling
	logic [SPAN_W-1:0] d;
	logic [SPAN_W-1:0] dneg;
	logic              dpos;
	logic              dpos_q;
	logic [DMAG_W-1:0] dabs_q;
	logic [COEF_W-1:0] coeff_q;
	logic [PROD_W-1:0] prod_q;

	assign d    = {val_q[VAL_W-1], val_q} - {base.ctr[VAL_W-1], base.ctr};
	assign dneg = -d;
	assign dpos = !d[SPAN_W-1] && (d != '0);

	always_ff @(posedge clk) begin
		if (cmd.d_ld) begin
			dpos_q  <= dpos;
			dabs_q  <= dpos ? d[DMAG_W-1:0] : dneg[DMAG_W-1:0];
			coeff_q <= dpos ? base.pc : base.nc;
		end
		if (cmd.mul)
			prod_q <= dabs_q * coeff_q;
	end

	logic [MAG_W-1:0] mag;
	logic [POS_W-1:0] m16;
	logic [POS_W-1:0] pos;
	logic             sat;

	assign mag = prod_q[PROD_W-1:FRAC_W];

	always_comb begin
		if (dpos_q) begin
			sat = mag > MAG_W'(32767);
			m16 = sat ? 16'h7FFF : mag[POS_W-1:0];
			pos = m16;
		end else begin
			sat = mag > MAG_W'(32768);
			m16 = sat ? 16'h8000 : mag[POS_W-1:0];
			pos = -m16;
		end
	end

	// output register
	logic [AXIS_W-1:0] ax_out_q;
	logic [POS_W-1:0]  pos_q;
	logic              sat_q;

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			ax_out_q <= ax_q;
			pos_q    <= pos;
			sat_q    <= sat;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'b000, pos_q, ax_out_q};
	assign m_tuser  = sat_q;

	always_comb begin
		sts.kind     = kind_q;
		sts.axis_ok  = axis_ok_q;
		sts.word_ok  = word_q inside {WORD_MIN, WORD_MAX, WORD_CTR};
		sts.cal      = cal_q;
		sts.sw_last  = sw_q == AW'(NUM_AXES - 1);
		sts.div_done = div_done;
		sts.out_busy = m_valid_q && !m_tready;
	end

endmodule

[sv/jacn_ctrl.sv]
`timescale 1ns / 1ps

module jacn_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	input  jacn_pkg::sts_t sts,
	output jacn_pkg::cmd_t cmd
);
	import jacn_pkg::*;

	state_t st_q;
	state_t st_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= ST_IDLE;
		else
			st_q <= st_nxt;
	end

	always_comb begin
		cmd    = '0;
		st_nxt = st_q;
		case (st_q)
			ST_IDLE: begin
				cmd.take = 1'b1;
				if (s_tvalid)
					st_nxt = ST_ROW;
			end
			// row of the item's axis was read on the accepting edge
			ST_ROW: begin
				case (sts.kind)
					REQ_START: begin
						cmd.cal_set  = 1'b1;
						cmd.seen_clr = 1'b1;
						st_nxt       = ST_IDLE;
					end
					REQ_STOP: begin
						cmd.sw_clr = 1'b1;
						st_nxt     = ST_SW_RD;
					end
					REQ_LOAD: begin
						if (sts.axis_ok && sts.word_ok) begin
							cmd.row_ld   = 1'b1;
							cmd.row_mode = ROW_LOAD;
							st_nxt       = ST_DIV_P;
						end else begin
							st_nxt = ST_IDLE;
						end
					end
					REQ_SAMPLE: begin
						if (!sts.axis_ok) begin
							st_nxt = ST_IDLE;
						end else if (sts.cal) begin
							cmd.row_ld   = 1'b1;
							cmd.row_mode = ROW_CAL;
							cmd.seen_set = 1'b1;
							st_nxt       = ST_WR;
						end else begin
							cmd.row_ld   = 1'b1;
							cmd.row_mode = ROW_SAMP;
							cmd.d_ld     = 1'b1;
							st_nxt       = ST_MUL;
						end
					end
					default: st_nxt = ST_IDLE;
				endcase
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				cmd.wr  = 1'b1;
				st_nxt  = ST_OUT;
			end
			ST_OUT: begin
				if (!sts.out_busy) begin
					cmd.out_ld = 1'b1;
					st_nxt     = ST_IDLE;
				end
			end
			ST_SW_RD: begin
				cmd.rd_sweep = 1'b1;
				st_nxt       = ST_SW_ROW;
			end
			ST_SW_ROW: begin
				cmd.row_ld   = 1'b1;
				cmd.row_mode = ROW_STOP;
				st_nxt       = ST_DIV_P;
			end
			ST_DIV_P: begin
				cmd.div_start = 1'b1;
				st_nxt        = ST_WAIT_P;
			end
			ST_WAIT_P: begin
				if (sts.div_done) begin
					cmd.set_pc = 1'b1;
					st_nxt     = ST_DIV_N;
				end
			end
			ST_DIV_N: begin
				cmd.div_start = 1'b1;
				cmd.div_neg   = 1'b1;
				st_nxt        = ST_WAIT_N;
			end
			ST_WAIT_N: begin
				cmd.div_neg = 1'b1;
				if (sts.div_done) begin
					cmd.set_nc = 1'b1;
					st_nxt     = ST_WR;
				end
			end
			ST_WR: begin
				cmd.wr = 1'b1;
				if (sts.kind == REQ_STOP) begin
					if (sts.sw_last) begin
						cmd.cal_clr = 1'b1;
						st_nxt      = ST_IDLE;
					end else begin
						cmd.sw_inc = 1'b1;
						st_nxt     = ST_SW_RD;
					end
				end else begin
					st_nxt = ST_IDLE;
				end
			end
			default: st_nxt = ST_IDLE;
		endcase
	end

endmodule

[sv/joystick_axis_calibrate_normalize_top.sv]
// channel   dir  tdata (low bit up)                            tuser
// s_*       in   axis[4:0] which_word[6:5] value[23:7]         req_type[1:0]
// m_*       out  axis_out[4:0] position[20:5] zero[23:21]      saturated[0]
//
// One item at a time. A normal sample goes through accept, table read,
// multiply and output load; a calibration sample through accept, table read
// and table write, a start through accept and the calibration flag set.
// A table load and each axis of a stop run both coefficients through the
// bit-serial divider, and a span of zero or less skips the division.
// Reset clears the control state and the per-axis valid bits; no clearing pass.
// A result held by a stalled m_tready blocks only the next output load.
`timescale 1ns / 1ps
`include "joystick_axis_calibrate_normalize_top_macros.svh"

module joystick_axis_calibrate_normalize_top #(
	parameter int NUM_AXES = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [jacn_pkg::IN_TDATA_W-1:0]  s_tdata,   // axis, which_word, value
	input  logic [jacn_pkg::IN_TUSER_W-1:0]  s_tuser,   // req_type
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [jacn_pkg::OUT_TDATA_W-1:0] m_tdata,   // axis_out, position
	output logic [jacn_pkg::OUT_TUSER_W-1:0] m_tuser    // saturated
);
	import jacn_pkg::*;

	cmd_t cmd;
	sts_t sts;

	jacn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.sts      (sts),
		.cmd      (cmd)
	);

	jacn_dp #(
		.NUM_AXES (NUM_AXES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tvalid (s_tvalid),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	assign s_tready = cmd.take;

	`JACN_ASSERT_NXT(a_one_item, s_tvalid && s_tready, !s_tready, "second item taken while busy")
	`JACN_ASSERT_IMP(a_out_free, cmd.out_ld, !(m_tvalid && !m_tready), "result overwritten")
	`JACN_ASSERT_IMP(a_wr_busy, cmd.wr, !s_tready, "table write while idle")
	`JACN_ASSERT_IMP(a_out_src, $rose(m_tvalid), $past(cmd.out_ld), "result without load")

endmodule
